[design/ibd_pkg.sv]
// ----------------------------------------------------------------------------
// ibd_pkg
// Types, widths and constants shared by the I2C baud divisor datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ibd_pkg;

    // Field widths of the input and result items
    localparam int SRC_W  = 27;
    localparam int SCL_W  = 22;
    localparam int BAUD_W = 16;

    // Datapath widths: numerator src*(5 MHz - scl), denominator scl*5 MHz
    localparam int FIVE_W = 23;
    localparam int NUM_W  = SRC_W + FIVE_W;
    localparam int DEN_W  = SCL_W + FIVE_W;
    // Quotient bits kept; the top bit flags "at least 1024", which saturates
    localparam int Q_W    = 11;
    localparam int CMP_W  = DEN_W + Q_W - 1;

    // Request limits
    localparam logic [SRC_W-1:0]  DEFAULT_SRC_HZ = SRC_W'(48000000);
    localparam logic [SCL_W-1:0]  FAST_LIMIT_HZ  = SCL_W'(400000);
    localparam logic [SCL_W-1:0]  FPLUS_LIMIT_HZ = SCL_W'(1000000);
    localparam logic [FIVE_W-1:0] FIVE_MHZ       = FIVE_W'(5000000);

    // Raw count offset and clamp points, stated on the quotient (raw + 10)
    localparam logic [Q_W-1:0] RAW_OFFSET = Q_W'(10);
    localparam logic [Q_W-1:0] Q_SF_MAX   = Q_W'(520);
    localparam logic [Q_W-1:0] Q_SF_MIN   = Q_W'(11);
    localparam logic [Q_W-1:0] Q_FP_MAX   = Q_W'(392);
    localparam logic [Q_W-1:0] Q_FP_MIN   = Q_W'(13);

    // Divisor words at the clamp points
    localparam logic [BAUD_W-1:0] SF_DIV_MAX = 16'h00FF;
    localparam logic [BAUD_W-1:0] SF_DIV_MIN = 16'h0001;
    localparam logic [BAUD_W-1:0] FP_DIV_MAX = 16'hFF7F;
    localparam logic [BAUD_W-1:0] FP_DIV_MIN = 16'h0201;

    // Reciprocal of three for values below 1024: floor(x * 683 / 2048)
    localparam logic [9:0] RECIP3 = 10'd683;
    localparam int         RECIP3_SHIFT = 11;

    typedef struct packed {
        logic [SRC_W-1:0] source_clock_hz;
        logic [SCL_W-1:0] scl_rate_hz;
    } t_in_item;

    typedef struct packed {
        logic              rate_ok;
        logic [BAUD_W-1:0] baud_word;
        logic              fast_plus_mode;
    } t_out_item;

    // One stage of the division chain
    typedef struct packed {
        logic             valid;
        logic             ok;
        logic             fplus;
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   quo;
    } t_div_stage;

    // floor(x / 3) for x below 768, where the result fits in eight bits
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'(RECIP3);
        return prod[RECIP3_SHIFT +: 8];
    endfunction

endpackage

`default_nettype wire

[design/ibd_front.sv]
// ----------------------------------------------------------------------------
// ibd_front
// Takes a request item, checks it and forms numerator and denominator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibd_front
    import ibd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_in_item   i_item,
    input  wire logic       i_take,
    output logic            o_take,
    output t_div_stage      o_stage
);

    t_div_stage        r_stage;
    t_div_stage        n_stage;
    logic [SRC_W-1:0]  w_src;
    logic [SCL_W-1:0]  w_scl;
    logic [FIVE_W-1:0] w_span;

    // Load whenever this stage is empty or its item moves on
    assign o_take = !r_stage.valid || i_take;

    // Substitute the default clock, check limits, form both products
    always_comb begin
        w_src  = (i_item.source_clock_hz == '0) ? DEFAULT_SRC_HZ : i_item.source_clock_hz;
        w_scl  = i_item.scl_rate_hz;
        w_span = FIVE_MHZ - FIVE_W'(w_scl);

        n_stage       = '0;
        n_stage.valid = i_valid;
        n_stage.ok    = (w_scl != '0) && (w_scl <= FPLUS_LIMIT_HZ)
                        && ({1'b0, w_src} >= {w_scl, 1'b0} + (SRC_W + 1)'(0));
        n_stage.fplus = w_scl > FAST_LIMIT_HZ;
        n_stage.rem   = NUM_W'(w_src) * NUM_W'(w_span);
        n_stage.den   = DEN_W'(w_scl) * DEN_W'(FIVE_MHZ);
        n_stage.quo   = '0;
    end

    // Hold the stage register; reset clears only the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (o_take) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

[design/ibd_cell.sv]
// ----------------------------------------------------------------------------
// ibd_cell
// One restoring division step: settle quotient bit SHIFT of rem / den.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibd_cell
    import ibd_pkg::*;
#(
    parameter int SHIFT = 0
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_div_stage i_stage,
    input  wire logic       i_take,
    output logic            o_take,
    output t_div_stage      o_stage
);

    t_div_stage        r_stage;
    t_div_stage        n_stage;
    logic [CMP_W-1:0]  w_den_sh;
    logic [CMP_W-1:0]  w_rem_ext;
    logic [CMP_W-1:0]  w_diff;
    logic              w_geq;

    assign o_take = !r_stage.valid || i_take;

    // Compare against the shifted divisor and subtract when it fits
    always_comb begin
        w_den_sh  = CMP_W'(i_stage.den) << SHIFT;
        w_rem_ext = CMP_W'(i_stage.rem);
        w_geq     = w_rem_ext >= w_den_sh;
        w_diff    = w_rem_ext - w_den_sh;

        n_stage            = i_stage;
        n_stage.quo[SHIFT] = w_geq;
        if (w_geq) begin
            n_stage.rem = w_diff[NUM_W-1:0];
        end
    end

    // Hand the item to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (o_take) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

`default_nettype wire

[design/ibd_back.sv]
// ----------------------------------------------------------------------------
// ibd_back
// Clamps the quotient into a divisor word and holds the result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ibd_back
    import ibd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_div_stage i_stage,
    output logic            o_take,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_item
);

    logic              r_valid;
    t_out_item         r_item;
    t_out_item         n_item;
    logic [Q_W-1:0]    w_q;
    logic [Q_W-1:0]    w_raw;
    logic [8:0]        w_r;
    logic [BAUD_W-1:0] w_baud;

    assign o_take = !r_valid || i_ready;

    // Map the quotient to the divisor of the selected speed mode
    always_comb begin
        w_q   = i_stage.quo;
        w_raw = w_q - RAW_OFFSET;
        w_r   = w_raw[8:0];

        if (!i_stage.fplus) begin
            if (w_q > Q_SF_MAX) begin
                w_baud = SF_DIV_MAX;
            end else if (w_q <= Q_SF_MIN) begin
                w_baud = SF_DIV_MIN;
            end else begin
                w_baud = {8'h00, w_raw[8:1]};
            end
        end else begin
            if (w_q >= Q_FP_MAX) begin
                w_baud = FP_DIV_MAX;
            end else if (w_q <= Q_FP_MIN) begin
                w_baud = FP_DIV_MIN;
            end else begin
                w_baud = {div3({w_r, 1'b0}), div3({1'b0, w_r})};
            end
        end

        n_item                = '0;
        n_item.rate_ok        = i_stage.ok;
        n_item.baud_word      = i_stage.ok ? w_baud : '0;
        n_item.fast_plus_mode = i_stage.ok && i_stage.fplus;
    end

    // Hold the result until taken; load a new one when the slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[design/i2c_master_baud_divisor_calc_core.sv]
// ----------------------------------------------------------------------------
// i2c_master_baud_divisor_calc_core
// Computes the I2C master SCL divisor word and speed-mode bit per request.
//
//   Channel  Handshake           Payload     Item
//   in       i_valid / o_ready   i_item      source clock and SCL rate
//   out      o_valid / i_ready   o_item      ok flag, divisor word, mode bit
//
// One item per cycle while results are taken; the products are formed in
// the accept cycle and registered at the accept, 11 division cells settle
// one quotient bit each, and the back stage clamps and holds the result.
// Reset (i_rst_n low, synchronous) empties every stage.
// Each stage loads when empty or when its item moves on, so bubbles close
// up while the output waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_baud_divisor_calc_core
    import ibd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_out_item     o_item
);

    t_div_stage w_stage [0:Q_W];
    logic       w_take  [0:Q_W];

    // Check the request and form numerator and denominator
    ibd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_take  (w_take[0]),
        .o_take  (o_ready),
        .o_stage (w_stage[0])
    );

    // Settle quotient bits from the top down
    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        ibd_cell #(
            .SHIFT (Q_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_stage[g]),
            .i_take  (w_take[g+1]),
            .o_take  (w_take[g]),
            .o_stage (w_stage[g+1])
        );
    end

    // Clamp and hold the result item
    ibd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage[Q_W]),
        .o_take  (w_take[Q_W]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

[bench/tb_i2c_master_baud_divisor_calc_core.sv]
// ----------------------------------------------------------------------------
// tb_i2c_master_baud_divisor_calc_core
// Checks the SCL baud divisor core against a bit-exact predictor of the
// divisor word, the speed-mode bit and the reject flag. Directed requests
// cover the rejects, the default source clock and every clamp point. Random
// requests then follow: mostly well-formed ones aimed at the clamp
// boundaries, with full-width noise mixed in. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_baud_divisor_calc_core;

    import ibd_pkg::*;

    // Request limits, as the divisor rules state them
    localparam longint unsigned HZ_SRC_DEFAULT = 48000000;
    localparam longint unsigned HZ_FAST_MAX    = 400000;
    localparam longint unsigned HZ_FPLUS_MAX   = 1000000;
    localparam longint unsigned HZ_FIVE_M      = 5000000;
    localparam longint unsigned SRC_ALL_ONES   = 27'h7FFFFFF;
    localparam longint unsigned SCL_ALL_ONES   = 22'h3FFFFF;

    localparam int IDLE_PCT     = 15;
    localparam int RANDOM_ITEMS = 600;
    localparam int TAIL_CYCLES  = 30;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int CALM_START   = 1200;
    localparam int CALM_END     = 2000;
    localparam int REPORT_MAX   = 10;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      dut_ready;
    logic      dut_valid;
    t_out_item dut_item;

    t_in_item  pending_reqs[$];
    t_out_item expected_baud[$];

    bit in_fire = 1'b0;
    int cycle_count = 0;
    int req_count = 0;
    int reject_count = 0;
    int fplus_count = 0;
    int checked_count = 0;
    int mismatch_count = 0;

    wire calm_window = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

    i2c_master_baud_divisor_calc_core dut (
        .i_clk   (i_clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (dut_ready),
        .i_item  (in_item),
        .o_valid (dut_valid),
        .i_ready (out_ready),
        .o_item  (dut_item)
    );

    // Free-running clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predict the divisor word, mode bit and ok flag of one request
    function automatic t_out_item predict_baud(t_in_item req);
        longint unsigned src;
        longint unsigned scl;
        longint unsigned num;
        longint unsigned den;
        longint unsigned r;
        longint          raw;
        t_out_item       res;
        res = '0;
        src = req.source_clock_hz;
        scl = req.scl_rate_hz;
        if (src == 0) begin
            src = HZ_SRC_DEFAULT;
        end
        if (scl == 0 || scl > HZ_FPLUS_MAX || src < 2 * scl) begin
            return res;
        end
        num = src * (HZ_FIVE_M - scl);
        den = scl * HZ_FIVE_M;
        raw = longint'(num / den) - 10;
        res.rate_ok = 1'b1;
        if (scl <= HZ_FAST_MAX) begin
            res.fast_plus_mode = 1'b0;
            if (raw > 510) begin
                res.baud_word = 16'h00FF;
            end else if (raw <= 1) begin
                res.baud_word = 16'h0001;
            end else begin
                res.baud_word = 16'(raw / 2);
            end
        end else begin
            res.fast_plus_mode = 1'b1;
            if (raw >= 382) begin
                res.baud_word = 16'hFF7F;
            end else if (raw <= 3) begin
                res.baud_word = 16'h0201;
            end else begin
                r = unsigned'(raw);
                res.baud_word = {8'((r * 2) / 3), 8'(r / 3)};
            end
        end
        return res;
    endfunction

    // Smallest source clock whose quotient reaches q at the given SCL rate
    function automatic longint unsigned src_for_quotient(longint unsigned scl,
                                                         longint unsigned q);
        longint unsigned span;
        span = HZ_FIVE_M - scl;
        return (q * scl * HZ_FIVE_M + span - 1) / span;
    endfunction

    // Draw one random request: mostly well-formed, aimed near the clamp points
    function automatic t_in_item random_request();
        t_in_item        req;
        int unsigned     pick;
        longint unsigned scl;
        longint unsigned src;
        longint unsigned q;
        pick = $urandom_range(99);
        if (pick < 15) begin
            req.source_clock_hz = SRC_W'($urandom);
            req.scl_rate_hz     = SCL_W'($urandom);
            if ($urandom_range(9) == 0) begin
                req.source_clock_hz = '0;
            end
        end else if (pick < 30) begin
            req.scl_rate_hz     = SCL_W'($urandom_range(HZ_FPLUS_MAX, 1));
            req.source_clock_hz = ($urandom_range(7) == 0) ? '0 : SRC_W'($urandom);
        end else begin
            case ($urandom_range(5))
                0, 1: scl = $urandom_range(HZ_FAST_MAX, 1);
                2: scl = $urandom_range(2000, 1);
                3, 5: scl = $urandom_range(HZ_FPLUS_MAX, HZ_FAST_MAX + 1);
                default: begin
                    case ($urandom_range(3))
                        0: scl = 1;
                        1: scl = HZ_FAST_MAX;
                        2: scl = HZ_FAST_MAX + 1;
                        default: scl = HZ_FPLUS_MAX;
                    endcase
                end
            endcase
            case ($urandom_range(7))
                0: q = $urandom_range(16, 8);
                1: q = $urandom_range(396, 388);
                2: q = $urandom_range(524, 516);
                3: q = $urandom_range(1028, 1020);
                4: q = $urandom_range(2052, 2044);
                5: q = $urandom_range(3, 0);
                default: q = $urandom_range(1100, 0);
            endcase
            src = src_for_quotient(scl, q) + $urandom_range(2);
            if (src > SRC_ALL_ONES) begin
                src = $urandom_range(SRC_ALL_ONES, 2 * scl);
            end
            req.source_clock_hz = SRC_W'(src);
            req.scl_rate_hz     = SCL_W'(scl);
        end
        return req;
    endfunction

    task automatic queue_request(longint unsigned src, longint unsigned scl);
        t_in_item req;
        req.source_clock_hz = SRC_W'(src);
        req.scl_rate_hz     = SCL_W'(scl);
        pending_reqs.push_back(req);
    endtask

    // Hold until every queued request has gone in and every result has come
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (pending_reqs.size() != 0 || in_valid || expected_baud.size() != 0);
    endtask

    // Sample both handshakes: record accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        cycle_count <= cycle_count + 1;
        in_fire = rst_n && in_valid && dut_ready;
        if (in_fire) begin
            pred = predict_baud(in_item);
            expected_baud.push_back(pred);
            req_count++;
            if (!pred.rate_ok) begin
                reject_count++;
            end
            if (pred.fast_plus_mode) begin
                fplus_count++;
            end
        end
        if (rst_n && dut_valid && out_ready) begin
            if (expected_baud.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("ERROR: result with nothing expected: ok=%0b baud=%04h fp=%0b",
                             dut_item.rate_ok, dut_item.baud_word, dut_item.fast_plus_mode);
                end
            end else begin
                want = expected_baud.pop_front();
                checked_count++;
                if (dut_item.rate_ok !== want.rate_ok
                        || dut_item.baud_word !== want.baud_word
                        || dut_item.fast_plus_mode !== want.fast_plus_mode) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("ERROR: result %0d: ok exp %0b act %0b, baud exp %04h",
                                 checked_count, want.rate_ok, dut_item.rate_ok,
                                 want.baud_word);
                        $display("       baud act %04h, fp exp %0b act %0b",
                                 dut_item.baud_word, want.fast_plus_mode,
                                 dut_item.fast_plus_mode);
                    end
                end
            end
        end
    end

    // Drive requests and result-side ready at the falling edge
    always @(negedge i_clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            if (!in_valid || in_fire) begin
                if (pending_reqs.size() != 0
                        && (calm_window || $urandom_range(99) >= IDLE_PCT)) begin
                    in_item  <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= calm_window || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Sequence the run: reset, directed requests, two random phases
    initial begin
        int k;
        repeat (8) @(negedge i_clk);
        rst_n <= 1'b1;

        // Default source clock in each mode
        queue_request(0, 100000);
        queue_request(0, HZ_FAST_MAX);
        queue_request(0, HZ_FPLUS_MAX);
        // Rejects: zero rate, rate above 1 MHz, source below twice the rate
        queue_request(48000000, 0);
        queue_request(0, 0);
        queue_request(48000000, HZ_FPLUS_MAX + 1);
        queue_request(SRC_ALL_ONES, SCL_ALL_ONES);
        queue_request(1999999, HZ_FPLUS_MAX);
        queue_request(1, 1);
        // Exactly twice the rate: negative raw count clamps to the minimum
        queue_request(2000000, HZ_FPLUS_MAX);
        queue_request(800000, HZ_FAST_MAX);
        // Saturation at the top in standard mode
        queue_request(SRC_ALL_ONES, 1);
        queue_request(100000000, 100000);
        // Standard mode around the low and high clamp points
        queue_request(src_for_quotient(100000, 11), 100000);
        queue_request(src_for_quotient(100000, 12), 100000);
        queue_request(src_for_quotient(100000, 520), 100000);
        queue_request(src_for_quotient(100000, 521), 100000);
        // Fast-plus mode around the low and high clamp points
        queue_request(src_for_quotient(HZ_FPLUS_MAX, 13), HZ_FPLUS_MAX);
        queue_request(src_for_quotient(HZ_FPLUS_MAX, 14), HZ_FPLUS_MAX);
        queue_request(src_for_quotient(HZ_FPLUS_MAX, 391), HZ_FPLUS_MAX);
        queue_request(src_for_quotient(HZ_FPLUS_MAX, 392), HZ_FPLUS_MAX);
        // Mode boundary with mid-range divisors
        queue_request(src_for_quotient(HZ_FAST_MAX, 200), HZ_FAST_MAX);
        queue_request(src_for_quotient(HZ_FAST_MAX + 1, 200), HZ_FAST_MAX + 1);
        wait_drained();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            pending_reqs.push_back(random_request());
        end
        // Pause the sender until the pipeline has emptied
        wait_drained();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            pending_reqs.push_back(random_request());
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d requests sent, %0d results checked, %0d mismatches",
                 req_count, checked_count, mismatch_count);
        $display("Summary: %0d rejected requests, %0d fast-plus divisors",
                 reject_count, fplus_count);
        if (mismatch_count == 0 && expected_baud.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, expected_baud.size());
        $display("Verification failed");
        $finish;
    end

endmodule
